### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the RTL checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Check that a condition never holds outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    `ASSERT_CLK(lbl, clk, rst_n, !(cond))

`endif

### rtl/rnh_pkg.sv
// ----------------------------------------------------------------------------
// rnh_pkg
// Shared constants for the height-order rational successor block.
// ----------------------------------------------------------------------------
package rnh_pkg;

    // Width of every numeric field on the ports
    localparam int FIELD_W = 32;

    // Default internal word width
    localparam int DEFAULT_WIDTH = 32;

endpackage

### rtl/rational_next_by_height.sv
// ----------------------------------------------------------------------------
// rational_next_by_height
// Successor of a nonnegative fraction num/den in the height enumeration.
// ----------------------------------------------------------------------------
// Takes p/q and returns the next fraction ordered by height: q/p when
// 0 < p < q, else the first k/p with q < k <= p and k coprime to p, else
// 1/(p+1) (overflow set and next_den wrapped to 0 when p is all ones).
// One transaction is worked at a time. A direct case goes to ST_FINISH,
// which loads the output register once it is free; the block is ready
// again in the same cycle that the result shows. A search passes through
// ST_STEP for each candidate and then ST_GCD, one binary-gcd step per
// cycle; the fallback to 1/(p+1) passes ST_STEP once more, and ST_FINISH
// loads the output register. There are no candidates when q >= p.
// Otherwise the number of candidates is set by the run of integers just
// above q that share a factor with p, a few dozen at most for 32-bit words.
// A new transaction is accepted while the previous result still waits in
// the output register; a finished result holds the block busy until the
// output register is free.
// ----------------------------------------------------------------------------
module rational_next_by_height #(
    parameter int WIDTH = rnh_pkg::DEFAULT_WIDTH
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [rnh_pkg::FIELD_W-1:0] s_num,
    input  logic [rnh_pkg::FIELD_W-1:0] s_den,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [rnh_pkg::FIELD_W-1:0] m_next_num,
    output logic [rnh_pkg::FIELD_W-1:0] m_next_den,
    output logic                        m_overflow
);

    localparam int FW = rnh_pkg::FIELD_W;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_STEP   = 2'd1;
    localparam logic [1:0] ST_GCD    = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic             m_valid_reg, m_valid_next;
    logic [WIDTH-1:0] p_reg, p_next;
    logic [WIDTH-1:0] q_reg, q_next;
    logic [WIDTH-1:0] a_reg, a_next;
    logic [WIDTH-1:0] b_reg, b_next;
    logic [WIDTH-1:0] res_num_reg, res_num_next;
    logic [WIDTH-1:0] res_den_reg, res_den_next;
    logic             res_ovf_reg, res_ovf_next;
    logic [FW-1:0]    out_num_reg, out_num_next;
    logic [FW-1:0]    out_den_reg, out_den_next;
    logic             out_ovf_reg, out_ovf_next;

    logic [WIDTH-1:0] in_p, in_q;
    logic [WIDTH:0]   diff_ab;
    logic [WIDTH-1:0] diff_ba;
    logic             accept, out_free;

    assign in_p     = WIDTH'(s_num);
    assign in_q     = WIDTH'(s_den);
    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // Shared gcd unit: both differences of the odd operands
    assign diff_ab = {1'b0, a_reg} - {1'b0, b_reg};
    assign diff_ba = b_reg - a_reg;

    // Sequencer and datapath next values
    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        p_next       = p_reg;
        q_next       = q_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        res_num_next = res_num_reg;
        res_den_next = res_den_reg;
        res_ovf_next = res_ovf_reg;
        out_num_next = out_num_reg;
        out_den_next = out_den_reg;
        out_ovf_next = out_ovf_reg;

        // Drop the result once taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    p_next = in_p;
                    q_next = in_q;
                    if (in_p != '0 && in_p < in_q) begin
                        res_num_next = in_q;
                        res_den_next = in_p;
                        res_ovf_next = 1'b0;
                        state_next   = ST_FINISH;
                    end else begin
                        state_next = ST_STEP;
                    end
                end
            end
            ST_STEP: begin
                // Advance to the next candidate or fall back to 1/(p+1)
                if (q_reg < p_reg) begin
                    q_next     = q_reg + WIDTH'(1);
                    a_next     = p_reg;
                    b_next     = q_reg + WIDTH'(1);
                    state_next = ST_GCD;
                end else begin
                    res_num_next = WIDTH'(1);
                    res_den_next = p_reg + WIDTH'(1);
                    res_ovf_next = (p_reg == '1);
                    state_next   = ST_FINISH;
                end
            end
            ST_GCD: begin
                // One binary gcd step per cycle
                if (!a_reg[0] && !b_reg[0]) begin
                    state_next = ST_STEP;
                end else if (!a_reg[0]) begin
                    a_next = a_reg >> 1;
                end else if (!b_reg[0]) begin
                    b_next = b_reg >> 1;
                end else if (diff_ab == '0) begin
                    if (a_reg == WIDTH'(1)) begin
                        res_num_next = q_reg;
                        res_den_next = p_reg;
                        res_ovf_next = 1'b0;
                        state_next   = ST_FINISH;
                    end else begin
                        state_next = ST_STEP;
                    end
                end else if (!diff_ab[WIDTH]) begin
                    a_next = diff_ab[WIDTH-1:0] >> 1;
                end else begin
                    b_next = diff_ba >> 1;
                end
            end
            ST_FINISH: begin
                // Hold until the output register is free
                if (out_free) begin
                    m_valid_next = 1'b1;
                    out_num_next = FW'(res_num_reg);
                    out_den_next = FW'(res_den_reg);
                    out_ovf_next = res_ovf_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        p_reg       <= p_next;
        q_reg       <= q_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        res_num_reg <= res_num_next;
        res_den_reg <= res_den_next;
        res_ovf_reg <= res_ovf_next;
        out_num_reg <= out_num_next;
        out_den_reg <= out_den_next;
        out_ovf_reg <= out_ovf_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_next_num = out_num_reg;
    assign m_next_den = out_den_reg;
    assign m_overflow = out_ovf_reg;

endmodule

### rtl/rnh_checker.sv
// ----------------------------------------------------------------------------
// rnh_checker
// Port-level assertions for the height-order rational successor block.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rnh_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [rnh_pkg::FIELD_W-1:0] m_next_num,
    input logic [rnh_pkg::FIELD_W-1:0] m_next_den,
    input logic                        m_overflow
);

    // Hold a stalled result transaction
    `ASSERT_CLK(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid)

    // Each accepted transaction makes the block busy and drops s_ready
    `ASSERT_CLK(a_busy_after_accept, aclk, aresetn, s_valid && s_ready |=> !s_ready)

    // Overflow only on the 1/(p+1) fallback with a wrapped denominator
    `ASSERT_CLK(a_ovf_shape, aclk, aresetn,
        m_valid && m_overflow |-> m_next_num == 1 && m_next_den == '0)

    // A delivered numerator is never zero
    `ASSERT_NEVER(a_num_nonzero, aclk, aresetn, m_valid && m_next_num == '0)

endmodule

bind rational_next_by_height rnh_checker u_rnh_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_valid    (s_valid),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_next_num (m_next_num),
    .m_next_den (m_next_den),
    .m_overflow (m_overflow)
);

### dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the height-order rational successor block.
// ----------------------------------------------------------------------------
// Drives num/den transactions in bursts with random gaps and predicts each
// successor fraction in a scoreboard. The result channel stalls on its own
// pattern. The stimulus covers directed corner fractions, walks along the
// height enumeration, reciprocal and search cases, and words near all ones.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int          FIELD_W     = rnh_pkg::FIELD_W;
    localparam int          CLK_HALF    = 6;
    localparam int          RESET_CYC   = 11;
    localparam int          RANDOM_ITEMS = 600;
    localparam int          STALL_LIMIT = 40000;
    localparam int          DRAIN_CYC   = 200;
    localparam logic [FIELD_W-1:0] ALL_ONES = '1;

    typedef struct {
        logic [FIELD_W-1:0] num;
        logic [FIELD_W-1:0] den;
        logic               ovf;
    } successor_t;

    // Holds the expected successors and compares the block's results
    class height_scoreboard;
        successor_t  expected_q[$];
        int unsigned errors;

        function new();
            errors = 0;
        endfunction

        function longint unsigned word_gcd(longint unsigned a, longint unsigned b);
            longint unsigned r;
            while (b != 0) begin
                r = a % b;
                a = b;
                b = r;
            end
            return a;
        endfunction

        // Successor of p/q in height order
        function successor_t next_by_height(logic [FIELD_W-1:0] p, logic [FIELD_W-1:0] q);
            successor_t      s;
            longint unsigned pw;
            longint unsigned qw;
            bit              found;
            pw    = p;
            qw    = q;
            found = 1'b0;
            s.num = '0;
            s.den = '0;
            s.ovf = 1'b0;
            if (pw != 0 && pw < qw) begin
                s.num = q;
                s.den = p;
                found = 1'b1;
            end else begin
                // advance the candidate until one is coprime to p
                while (qw < pw && !found) begin
                    qw = qw + 1;
                    if (word_gcd(pw, qw) == 1) begin
                        s.num = qw[FIELD_W-1:0];
                        s.den = p;
                        found = 1'b1;
                    end
                end
            end
            if (!found) begin
                s.num = 1;
                if (p == ALL_ONES) begin
                    s.den = '0;
                    s.ovf = 1'b1;
                end else begin
                    s.den = p + 1'b1;
                end
            end
            return s;
        endfunction

        function void note_input(logic [FIELD_W-1:0] p, logic [FIELD_W-1:0] q);
            expected_q.push_back(next_by_height(p, q));
        endfunction

        function void check_result(logic [FIELD_W-1:0] num, logic [FIELD_W-1:0] den,
                                   logic ovf);
            successor_t e;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result %0d/%0d overflow %0b", $time, num, den, ovf);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (num !== e.num) begin
                $display("%0t: next_num expected %0d actual %0d", $time, e.num, num);
                errors++;
            end
            if (den !== e.den) begin
                $display("%0t: next_den expected %0d actual %0d", $time, e.den, den);
                errors++;
            end
            if (ovf !== e.ovf) begin
                $display("%0t: overflow expected %0b actual %0b", $time, e.ovf, ovf);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic               aclk;
    logic               aresetn    = 1'b0;
    logic               s_valid    = 1'b0;
    logic               s_ready;
    logic [FIELD_W-1:0] s_num      = '0;
    logic [FIELD_W-1:0] s_den      = '0;
    logic               m_valid;
    logic               m_ready    = 1'b0;
    logic [FIELD_W-1:0] m_next_num;
    logic [FIELD_W-1:0] m_next_den;
    logic               m_overflow;

    height_scoreboard   sb = new();
    int                 burst_left = 0;
    int unsigned        idle_cycles = 0;
    logic [11:0]        rx_cycle = '0;

    rational_next_by_height u_top (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_num      (s_num),
        .s_den      (s_den),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_next_num (m_next_num),
        .m_next_den (m_next_den),
        .m_overflow (m_overflow)
    );

    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    // Note accepted inputs and check accepted results
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                sb.note_input(s_num, s_den);
            end
            if (m_valid && m_ready) begin
                sb.check_result(m_next_num, m_next_den, m_overflow);
            end
        end
    end

    // Stall the result channel: always ready, random, sparse, then slow toggling
    always @(posedge aclk) begin
        rx_cycle <= rx_cycle + 1'b1;
        case (rx_cycle[9:8])
            2'd0: m_ready <= 1'b1;
            2'd1: m_ready <= 1'($urandom_range(0, 1));
            2'd2: m_ready <= ($urandom_range(0, 7) == 0);
            default: m_ready <= rx_cycle[3];
        endcase
    end

    // End the run when no transaction moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [FIELD_W-1:0] rand_word();
        int unsigned len;
        len = $urandom_range(1, FIELD_W);
        return $urandom & (ALL_ONES >> (FIELD_W - len));
    endfunction

    // Present one fraction and hold it until accepted; open a random gap, sometimes none, between bursts
    task automatic send_item(input logic [FIELD_W-1:0] n, input logic [FIELD_W-1:0] d);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 10);
        end
        burst_left--;
        s_valid <= 1'b1;
        s_num   <= n;
        s_den   <= d;
        do @(posedge aclk); while (!s_ready);
    endtask

    initial begin
        logic [FIELD_W-1:0] n;
        logic [FIELD_W-1:0] d;
        logic [FIELD_W-1:0] chain_num;
        logic [FIELD_W-1:0] chain_den;
        successor_t         step;
        int                 kind;

        repeat (RESET_CYC) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed corners: zero, one, reciprocal, search, wrap and overflow
        send_item(32'd0, 32'd1);
        send_item(32'd0, 32'd0);
        send_item(32'd0, ALL_ONES);
        send_item(32'd1, 32'd1);
        send_item(32'd1, 32'd0);
        send_item(32'd1, 32'd2);
        send_item(32'd2, 32'd1);
        send_item(32'd3, 32'd1);
        send_item(32'd4, 32'd3);
        send_item(32'd5, 32'd0);
        send_item(32'd6, 32'd4);
        send_item(32'd1, ALL_ONES);
        send_item(ALL_ONES - 1, ALL_ONES);
        send_item(ALL_ONES, 32'd1);
        send_item(ALL_ONES, 32'd0);
        send_item(ALL_ONES, ALL_ONES - 1);
        send_item(ALL_ONES, ALL_ONES);
        send_item(32'd223092870, 32'd1);
        send_item(32'd223092870, 32'd223092868);
        send_item(32'd223092870, 32'd223092869);
        send_item(32'hAAAAAAAA, 32'h55555555);
        send_item(32'h55555555, 32'hAAAAAAAA);

        // Random part: enumeration walks, reciprocals, searches, near-overflow, noise
        chain_num = 32'd0;
        chain_den = 32'd1;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            kind = $urandom_range(0, 9);
            case (kind)
                0, 1, 2: begin
                    n    = chain_num;
                    d    = chain_den;
                    step = sb.next_by_height(n, d);
                    chain_num = step.num;
                    chain_den = step.den;
                    if ($urandom_range(0, 24) == 0) begin
                        chain_num = $urandom_range(0, 2000);
                        chain_den = $urandom_range(1, 2000);
                    end
                end
                3, 4, 5: begin
                    n = rand_word();
                    d = rand_word();
                    if (n > d) begin
                        {n, d} = {d, n};
                    end
                end
                6, 7: begin
                    n = rand_word();
                    d = $urandom_range(0, n);
                end
                8: begin
                    n = ALL_ONES - $urandom_range(0, 3);
                    d = $urandom_range(0, 1) ? n - $urandom_range(0, 2) : $urandom_range(0, 5);
                end
                default: begin
                    n = $urandom;
                    d = ($urandom_range(0, 7) == 0) ? '0 : $urandom;
                end
            endcase
            send_item(n, d);
        end
        s_valid <= 1'b0;

        // Let the last accepted transaction reach the scoreboard before draining
        @(posedge aclk);

        // Drain the remaining results, then allow a quiet tail
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYC) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
